FILE: hdl/ske_pkg.sv
// Shared types and constants of the session key padding block.
package ske_pkg;

    localparam int unsigned MIN_PAD_BYTES = 8;

    localparam logic [7:0] START_MARK = 8'h02;
    localparam logic [7:0] SEPARATOR  = 8'h00;

    localparam logic FUNC_PAD = 1'b0;
    localparam logic FUNC_KEY = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT_PAD = 2'd1;
    localparam logic [1:0] ST_ORDER     = 2'd2;

    localparam logic [1:0] REG_BLOCK_LEN = 2'd0;
    localparam logic [1:0] REG_KEY_LEN   = 2'd1;
    localparam logic [1:0] REG_ALGO_ID   = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PAD  = 2'd1,
        PH_KEY  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [9:0] block_len;
        logic [5:0] key_len;
        logic [7:0] algo_id;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic [1:0]       cnt;
        res_t [2:0]       res;
    } bundle_t;

endpackage

FILE: hdl/ske_cfg.sv
// Configuration register file with its APB-style access port.
module ske_cfg
    import ske_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_len <= 10'd255;
            cfg_reg.key_len   <= 6'd16;
            cfg_reg.algo_id   <= 8'd0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_BLOCK_LEN: cfg_reg.block_len <= pwdata[9:0];
                REG_KEY_LEN:   cfg_reg.key_len   <= pwdata[5:0];
                REG_ALGO_ID:   cfg_reg.algo_id   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BLOCK_LEN: prdata = {22'd0, cfg_reg.block_len};
            REG_KEY_LEN:   prdata = {26'd0, cfg_reg.key_len};
            REG_ALGO_ID:   prdata = {24'd0, cfg_reg.algo_id};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/ske_step.sv
// Block state and the per-transaction step logic that forms up to three result bytes.
module ske_step
    import ske_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       take,
    input  logic       func,
    input  logic [7:0] data_byte,
    output bundle_t    bundle
);

    phase_t      phase_reg, phase_next;
    logic [9:0]  position_reg, position_next;
    logic [15:0] key_sum_reg, key_sum_next;

    logic [7:0]         klen;
    logic [7:0]         effk;
    logic signed [11:0] pad_len;
    logic [9:0]         pos_inc;
    logic [15:0]        sum_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            position_reg <= 10'd0;
            key_sum_reg  <= 16'd0;
        end else if (take) begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            key_sum_reg  <= key_sum_next;
        end
    end

    always_comb begin
        klen = {2'b00, cfg.key_len};
        effk = klen;
        if (klen == 8'd0) begin
            effk = 8'd1;
        end else if (klen > 8'(MAX_KEY_BYTES)) begin
            effk = 8'(MAX_KEY_BYTES);
        end
        pad_len = $signed({2'b00, cfg.block_len}) - $signed({4'b0000, effk}) - 12'sd5;
        pos_inc = position_reg + 10'd1;
        sum_inc = key_sum_reg + {8'd0, data_byte};
    end

    always_comb begin
        phase_next    = phase_reg;
        position_next = position_reg;
        key_sum_next  = key_sum_reg;
        bundle        = '0;
        unique case (phase_reg)
            PH_PAD: begin
                if (func != FUNC_PAD) begin
                    bundle.cnt    = 2'd1;
                    bundle.res[0] = '{8'd0, 1'b1, ST_ORDER};
                    phase_next    = PH_IDLE;
                    position_next = 10'd0;
                    key_sum_next  = 16'd0;
                end else if (data_byte != 8'd0) begin
                    bundle.cnt    = 2'd1;
                    bundle.res[0] = '{data_byte, 1'b0, ST_OK};
                    position_next = pos_inc;
                    if ($signed({2'b00, pos_inc}) >= pad_len) begin
                        bundle.cnt    = 2'd3;
                        bundle.res[1] = '{SEPARATOR, 1'b0, ST_OK};
                        bundle.res[2] = '{cfg.algo_id, 1'b0, ST_OK};
                        phase_next    = PH_KEY;
                        position_next = 10'd0;
                        key_sum_next  = 16'd0;
                    end
                end
            end
            PH_KEY: begin
                if (func != FUNC_KEY) begin
                    bundle.cnt    = 2'd1;
                    bundle.res[0] = '{8'd0, 1'b1, ST_ORDER};
                    phase_next    = PH_IDLE;
                    position_next = 10'd0;
                    key_sum_next  = 16'd0;
                end else begin
                    bundle.cnt    = 2'd1;
                    bundle.res[0] = '{data_byte, 1'b0, ST_OK};
                    key_sum_next  = sum_inc;
                    position_next = pos_inc;
                    if (pos_inc >= {2'b00, effk}) begin
                        bundle.cnt    = 2'd3;
                        bundle.res[1] = '{sum_inc[15:8], 1'b0, ST_OK};
                        bundle.res[2] = '{sum_inc[7:0], 1'b1, ST_OK};
                        phase_next    = PH_IDLE;
                        position_next = 10'd0;
                        key_sum_next  = 16'd0;
                    end
                end
            end
            default: begin
                if (pad_len < $signed(12'(MIN_PAD_BYTES))) begin
                    bundle.cnt    = 2'd1;
                    bundle.res[0] = '{8'd0, 1'b1, ST_SHORT_PAD};
                    phase_next    = PH_IDLE;
                    position_next = 10'd0;
                    key_sum_next  = 16'd0;
                end else if (func != FUNC_PAD) begin
                    bundle.cnt    = 2'd1;
                    bundle.res[0] = '{8'd0, 1'b1, ST_ORDER};
                    phase_next    = PH_IDLE;
                    position_next = 10'd0;
                    key_sum_next  = 16'd0;
                end else if (data_byte != 8'd0) begin
                    bundle.cnt    = 2'd2;
                    bundle.res[0] = '{START_MARK, 1'b0, ST_OK};
                    bundle.res[1] = '{data_byte, 1'b0, ST_OK};
                    phase_next    = PH_PAD;
                    position_next = 10'd1;
                    key_sum_next  = 16'd0;
                end
            end
        endcase
    end

endmodule

FILE: hdl/ske_ser.sv
// Result register that holds up to three bytes of one step and sends them one per cycle while m_tready is high.
module ske_ser
    import ske_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  bundle_t bundle,
    output logic    free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output res_t    head
);

    logic [1:0]  cnt_reg, cnt_next;
    res_t [2:0]  ent_reg, ent_next;
    logic        pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid & m_tready;
    assign free     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign head     = ent_reg[0];

    always_comb begin
        cnt_next = cnt_reg;
        ent_next = ent_reg;
        if (load) begin
            cnt_next = bundle.cnt;
            ent_next = bundle.res;
        end else if (pop) begin
            cnt_next    = cnt_reg - 2'd1;
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

FILE: hdl/session_key_eme_padder.sv
// Top level of the session key block padder (encryption padding as a byte stream).
//
//  Channel   Direction  Carries
//  s_*       in         tdata = random or key byte, tuser = kind (0 pad, 1 key)
//  m_*       out        tdata = block byte, tuser = status, tlast = end of block or error
//  APB       in/out     block_len @0x0, key_len @0x4, algo_id @0x8
//
// A transaction is evaluated in the cycle it is accepted and its up to three
// result bytes are loaded into the output register, which sends one per cycle
// while m_tready is high. Single-result transactions then flow at one per cycle;
// a three-byte result holds s_tready low while the output register drains.
// Reset is synchronous and active low; it returns the block to idle.
// A stall on m_tready holds the output and, once the last byte waits, s_tready.
module session_key_eme_padder
    import ske_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    bundle_t bundle;
    res_t    head;
    logic    free;
    logic    take;

    assign s_tready = free;
    assign take     = s_tvalid & free;
    assign m_tdata  = head.out_byte;
    assign m_tuser  = head.status;
    assign m_tlast  = head.last;

    ske_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ske_step #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .take      (take),
        .func      (s_tuser),
        .data_byte (s_tdata),
        .bundle    (bundle)
    );

    ske_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .bundle   (bundle),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

endmodule
